// File: sv/mau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mau_pkg;
  localparam int OperandWidth = 64;
  localparam int ModWidth = 31;
  localparam logic [ModWidth-1:0] ModulusReset = 31'd1000000007;
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_MUL = 2'd1;
  localparam logic [1:0] CMD_POW = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;
endpackage
`default_nettype wire

// File: sv/mau_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring remainder unit: magnitude of a 64-bit dividend modulo a 31-bit
// divisor, one dividend bit per cycle. The result is an unsigned remainder.
module mau_rem import mau_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [OperandWidth-1:0] dividend,
  input  wire logic [ModWidth-1:0]     divisor,
  output logic                         done,
  output logic [ModWidth-1:0]          remainder
);
  logic [OperandWidth-1:0] shreg;
  logic [ModWidth:0] part;
  logic [6:0] count;
  logic busy;
  logic [ModWidth+1:0] trial;

  assign trial = {part, shreg[OperandWidth-1]} - {2'b00, divisor};
  assign remainder = part[ModWidth-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd0;
        shreg <= dividend;
        part <= '0;
      end else if (busy) begin
        if (!trial[ModWidth+1]) part <= trial[ModWidth:0];
        else part <= {part[ModWidth-1:0], shreg[OperandWidth-1]};
        shreg <= {shreg[OperandWidth-2:0], 1'b0};
        count <= count + 7'd1;
        if (count == 7'(OperandWidth - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/modular_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Beat contents
// s_axis   | in        | tdata: command[1:0], operand_a[65:2], operand_b[129:66]
// m_axis   | out       | tdata: residue[30:0]
// cfg      | in        | modulus write (cfg_wdata[30:0])
// One shared remainder unit does every reduction. Add and multiply take three
// reductions; a reserved command takes none and returns zero. Power takes one
// for the base, then for each exponent bit a step state, a reduction for the
// multiply when the bit is set, and one for the square. Reset is synchronous
// and restores the modulus to 1000000007. The block takes one command at a
// time and is not ready while a residue waits.
module modular_arithmetic_unit import mau_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [30:0]  cfg_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // command, operand_a, operand_b, zero pad
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [31:0]       m_axis_tdata   // residue, zero pad
);
  localparam logic [3:0] ST_IDLE = 4'd0, ST_RA = 4'd1, ST_RB = 4'd2, ST_FIN = 4'd3,
                         ST_PMUL = 4'd4, ST_PSQ = 4'd5, ST_OUT = 4'd6, ST_PBASE = 4'd7;
  logic [3:0] state;
  logic [ModWidth-1:0] modulus, mval, ra, acc, bse, res;
  logic [1:0] cmd;
  logic [OperandWidth-1:0] opb, exp;
  logic nega, negb, rstart, rdone;
  logic [OperandWidth-1:0] rdiv;
  logic [ModWidth-1:0] rrem;
  logic [ModWidth-1:0] rnorm;
  logic [ModWidth-1:0] mul_x, mul_y;
  logic [2*ModWidth-1:0] prod;

  assign mval = (modulus == '0) ? 31'd1 : modulus;
  mau_rem u_rem (.clk, .rst, .start(rstart), .dividend(rdiv), .divisor(mval),
                 .done(rdone), .remainder(rrem));

  // Signed remainder of magnitude r, sign s, normalized to [0,m)
  function automatic logic [ModWidth-1:0] fixs(input logic [ModWidth-1:0] r,
                                                 input logic s,
                                                 input logic [ModWidth-1:0] m);
    logic [ModWidth:0] t;
    t = {1'b0, m} - {1'b0, r};
    fixs = (s && r != '0) ? t[ModWidth-1:0] : r;
  endfunction
  assign rnorm = rrem;

  // One multiplier serves the operand product, the power multiply and the
  // power square; the state picks its operands.
  always_comb begin
    mul_x = bse;
    mul_y = bse;
    if (state == ST_RB) begin
      mul_x = ra;
      mul_y = fixs(rnorm, negb, mval);
    end else if (state == ST_PBASE && exp[0]) begin
      mul_x = acc;
    end
  end
  assign prod = {{ModWidth{1'b0}}, mul_x} * {{ModWidth{1'b0}}, mul_y};

  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata = {1'b0, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ModulusReset;
      state <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      rstart <= 1'b0;
    end else begin
      if (cfg_we) modulus <= cfg_wdata;
      rstart <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          cmd <= s_axis_tdata[1:0];
          opb <= s_axis_tdata[129:66];
          nega <= s_axis_tdata[65];
          negb <= s_axis_tdata[129];
          exp <= s_axis_tdata[129:66];
          rdiv <= s_axis_tdata[65] ? -s_axis_tdata[65:2] : s_axis_tdata[65:2];
          if (s_axis_tdata[1:0] == CMD_POW || s_axis_tdata[1:0] == CMD_ADD ||
              s_axis_tdata[1:0] == CMD_MUL) begin
            rstart <= 1'b1;
            state <= ST_RA;
          end else begin
            res <= '0;
            state <= ST_OUT;
          end
        end
        ST_RA: if (rdone) begin
          ra <= fixs(rnorm, nega, mval);
          if (cmd == CMD_POW) begin
            bse <= fixs(rnorm, nega, mval);
            acc <= (mval == 31'd1) ? '0 : 31'd1;
            if (negb || exp == '0) begin
              res <= 31'd1;
              state <= ST_OUT;
            end else state <= ST_PBASE;
          end else begin
            rdiv <= negb ? -opb : opb;
            rstart <= 1'b1;
            state <= ST_RB;
          end
        end
        ST_RB: if (rdone) begin
          if (cmd == CMD_ADD)
            rdiv <= {32'd0, {1'b0, ra} + {1'b0, fixs(rnorm, negb, mval)}};
          else
            rdiv <= {2'b00, prod};
          rstart <= 1'b1;
          state <= ST_FIN;
        end
        ST_FIN: if (rdone) begin
          res <= rnorm;
          state <= ST_OUT;
        end
        ST_PBASE: begin
          if (exp == '0) begin
            res <= acc;
            state <= ST_OUT;
          end else if (exp[0]) begin
            rdiv <= {2'b00, prod};
            rstart <= 1'b1;
            state <= ST_PMUL;
          end else begin
            rdiv <= {2'b00, prod};
            rstart <= 1'b1;
            state <= ST_PSQ;
          end
        end
        ST_PMUL: if (rdone) begin
          acc <= rnorm;
          rdiv <= {2'b00, prod};
          rstart <= 1'b1;
          state <= ST_PSQ;
        end
        ST_PSQ: if (rdone) begin
          bse <= rnorm;
          exp <= exp >> 1;
          state <= ST_PBASE;
        end
        ST_OUT: if (!m_axis_tvalid) begin
          m_axis_tvalid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_res_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res < mval || res == 31'd1)) else $error("residue range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_start_pulse: assert property (@(posedge clk) disable iff (rst)
    rstart |=> !rstart) else $error("start not a pulse");
endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

// Residue scoreboard: predicts each result from the accepted command beat and
// checks results in arrival order.
class residue_scoreboard;
  logic [30:0] modulus;
  logic [30:0] pending[$];
  int errors;

  function new();
    modulus = mau_pkg::ModulusReset;
    errors = 0;
  endfunction

  // Truncating remainder normalized into [0, m), as the block does it.
  static function longint norm_mod(longint x, longint m);
    longint r;
    r = x % m;
    return (r < 0) ? r + m : r;
  endfunction

  static function longint residue_of(logic [1:0] cmd, longint a, longint b, longint m);
    longint acc, sq, e;
    acc = 1;
    case (cmd)
      mau_pkg::CMD_ADD: return norm_mod((a % m) + (b % m), m);
      mau_pkg::CMD_MUL: return norm_mod((a % m) * (b % m), m);
      mau_pkg::CMD_POW: begin
        // A non-positive exponent yields 1, even when m is 1.
        if (b <= 0) return 1;
        sq = norm_mod(a, m);
        e = b;
        while (e > 0) begin
          if (e[0]) acc = (acc * sq) % m;
          sq = (sq * sq) % m;
          e = e >>> 1;
        end
        return acc;
      end
      default: return 0;
    endcase
  endfunction

  function void note_command(logic [1:0] cmd, logic [63:0] a, logic [63:0] b);
    longint m;
    longint r;
    // A modulus of zero behaves as modulus one.
    m = (modulus == 0) ? 1 : longint'(modulus);
    r = residue_of(cmd, signed'(a), signed'(b), m);
    pending.insert(pending.size(), r[30:0]);
  endfunction

  function void check_residue(logic [31:0] data);
    logic [30:0] want;
    if (pending.size() == 0) begin
      $error("residue %0d arrived with nothing expected", data[30:0]);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (data[30:0] !== want) begin
      $error("residue: expected %0d, got %0d", want, data[30:0]);
      errors++;
    end
    if (data[31] !== 1'b0) begin
      $error("pad: expected 0, got %b", data[31]);
      errors++;
    end
  endfunction
endclass

module tb;
  import mau_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [30:0] cfg_wdata = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;  // command[1:0], operand_a[65:2], operand_b[129:66]
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;        // residue[30:0]

  residue_scoreboard board;
  longint unsigned cycles = 0;
  // When set, the receiver holds tready low for a long stretch so the block
  // backs up and stalls its input.
  bit hold_results = 0;

  modular_arithmetic_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Most gaps are short; a few are much longer.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 5);
    return $urandom_range(20, 400);
  endfunction

  // Operands that favor values near the edges of the signed 64-bit range and near zero.
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 50));
      2: v = -64'($urandom_range(1, 50));
      3: v = {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 3));
      4: v = {1'b1, 63'b0} + 64'($urandom_range(0, 3));
      default: v = {{32{$urandom_range(0, 1) == 1}}, $urandom};
    endcase
    return v;
  endfunction

  // Power exponents are mostly short so the run stays brief; a few are full width.
  function automatic logic [63:0] rand_exponent();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 64'($urandom_range(0, 255));
    if (p < 80) return -64'($urandom_range(0, 9));
    return {1'b0, 31'($urandom), $urandom} >> $urandom_range(0, 40);
  endfunction

  // Offers one command beat and waits until it is taken.
  task automatic send_command(logic [1:0] cmd, logic [63:0] a, logic [63:0] b);
    s_axis_tdata <= {6'b0, b, a, cmd};
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    board.note_command(cmd, a, b);
  endtask

  task automatic lower_valid_after_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Waits for every expected residue, then lets the block settle before a
  // modulus write.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_modulus(logic [30:0] m);
    cfg_wdata <= m;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    board.modulus = m;
  endtask

  task automatic random_phase(int count);
    logic [1:0] cmd;
    for (int i = 0; i < count; i++) begin
      cmd = 2'($urandom_range(0, 3));
      if (cmd == CMD_POW) send_command(cmd, rand_operand(), rand_exponent());
      else send_command(cmd, rand_operand(), rand_operand());
      lower_valid_after_gap();
    end
  endtask

  // Receiver: random backpressure, with one long hold-off when asked.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        m_axis_tready <= 0;
        repeat (3000) @(posedge clk);
        hold_results = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // Results are sampled at the edge where tvalid and tready are both high.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_residue(m_axis_tdata);
  end

  // Generous limit: about 160 commands at their worst case, plus stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed beats at the reset modulus: every command and the edge cases.
    send_command(CMD_ADD, 64'd5, 64'd7);
    send_command(CMD_ADD, {1'b1, 63'b0}, {1'b1, 63'b0});
    send_command(CMD_ADD, {1'b0, {63{1'b1}}}, -64'd1);
    send_command(CMD_MUL, {1'b0, {63{1'b1}}}, {1'b0, {63{1'b1}}});
    send_command(CMD_MUL, -64'd3, 64'd1000000006);
    send_command(CMD_MUL, {1'b1, 63'b0}, -64'd1);
    send_command(CMD_POW, 64'd2, 64'd10);
    send_command(CMD_POW, -64'd2, 64'd3);
    send_command(CMD_POW, 64'd7, 64'd0);
    send_command(CMD_POW, 64'd7, {1'b1, 63'b0});
    send_command(CMD_POW, {64{1'b1}}, {1'b0, {63{1'b1}}});
    send_command(CMD_RSVD, {64{1'b1}}, {64{1'b1}});
    drain();

    // Modulus one: every residue is zero except a power with exponent at most zero.
    write_modulus(31'd1);
    send_command(CMD_POW, 64'd5, 64'd0);
    send_command(CMD_POW, 64'd5, 64'd9);
    send_command(CMD_ADD, 64'd3, 64'd4);
    drain();

    // Zero written to the register behaves as modulus one.
    write_modulus(31'd0);
    send_command(CMD_MUL, 64'd3, 64'd4);
    send_command(CMD_POW, 64'd3, -64'd4);
    drain();

    // Largest modulus, with the receiver holding off so the block backs up.
    write_modulus({31{1'b1}});
    hold_results = 1;
    send_command(CMD_MUL, {1'b0, {63{1'b1}}}, -64'd2);
    send_command(CMD_ADD, -64'd1, -64'd1);
    send_command(CMD_POW, 64'd3, 64'd5);
    send_command(CMD_MUL, 64'd9, 64'd9);
    random_phase(30);
    drain();

    write_modulus(31'd97);
    random_phase(35);
    drain();

    write_modulus(31'($urandom_range(2, 32'h7FFF_FFFF)));
    random_phase(35);
    drain();

    write_modulus(ModulusReset);
    random_phase(35);
    drain();

    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// File: filelist.f
sv/mau_pkg.sv
sv/mau_rem.sv
sv/modular_arithmetic_unit.sv
dv/tb.sv
